>>> hw/rtl/rsc_pkg.sv
// shared types and constants for the richardson stability correction block
package rsc_pkg;

    // input word, one grid cell
    typedef struct packed {
        logic        [15:0] reference_height;
        logic        [15:0] displacement_height;
        logic signed [15:0] surface_temp;
        logic signed [15:0] air_temp;
        logic        [15:0] wind_speed;
        logic        [23:0] roughness_length;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [19:0] correction;
        logic [1:0]  status;
    } t_out_word;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // fixed point constants
    localparam logic [19:0] G_Q16      = 20'd642908;
    localparam int          KELVIN2_Q8 = 139853;
    localparam longint      LN2_Q16    = 45426;
    localparam longint      FIVE_Q16   = 327680;
    localparam logic [19:0] ONE_Q16    = 20'd65536;
    localparam logic [19:0] CORR_MAX   = 20'hFFFFF;
    localparam logic [15:0] CRIT_RESET = 16'd13107;

endpackage

>>> hw/rtl/richardson_stability_correction_top.sv
// richardson stability correction, fully pipelined top level
//
// usage:
//   input channel i_in_valid / o_in_ready carries one t_in_word per cell;
//   output channel o_out_valid / i_out_ready returns one t_out_word each.
//   i_cfg_we / i_cfg_data load the critical richardson number (Q0.16).
// timing:
//   110 register stages from input word to output register. one word per
//   cycle is accepted while the output word is not held; the length is set
//   by the bit-per-stage dividers (41, 34 and 23 stages); the 16-step log2
//   squaring chain rides along the first divider and adds no stages.
// stall:
//   when the output word is held and not taken the whole pipe freezes and
//   o_in_ready drops; nothing is lost or repeated. bubbles travel as
//   cleared valid bits.
// reset:
//   synchronous active-low i_rst_n clears all valid bits and loads the
//   critical richardson number with 0.2.
module richardson_stability_correction_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rsc_pkg::t_in_word i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rsc_pkg::t_out_word o_out_word,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);
    import rsc_pkg::*;

    // stage map
    localparam int STG_PREP  = 0;
    localparam int STG_MUL1  = 1;
    localparam int STG_MUL2  = 2;
    localparam int STG_D1I   = 3;
    localparam int STG_D1S   = 4;
    localparam int D1_BITS   = 41;
    localparam int STG_RI    = STG_D1S + D1_BITS;
    localparam int STG_LNP   = STG_RI + 1;
    localparam int STG_DEN   = STG_LNP + 1;
    localparam int STG_D2I   = STG_DEN + 1;
    localparam int STG_D2S   = STG_D2I + 1;
    localparam int D2_BITS   = 34;
    localparam int STG_LIM   = STG_D2S + D2_BITS;
    localparam int STG_D3I   = STG_LIM + 1;
    localparam int STG_D3S   = STG_D3I + 1;
    localparam int D3_BITS   = 23;
    localparam int SQ_BITS   = 18;
    localparam int STG_SQR   = STG_D3S + D3_BITS;
    localparam int STG_FIN   = STG_SQR + 1;
    localparam int NSTG      = STG_FIN + 1;
    localparam int LOG_STEPS = 16;

    // per-item working context
    typedef struct packed {
        logic               eq;
        logic               bad;
        logic               neg;
        logic        [15:0] h;
        logic        [15:0] mag;
        logic        [17:0] tm2;
        logic        [17:0] tak2;
        logic        [15:0] w;
        logic        [23:0] z0;
        logic        [35:0] a1;
        logic        [31:0] b1;
        logic        [60:0] num;
        logic        [49:0] dd;
        logic               ovf1;
        logic        [40:0] q1;
        logic        [3:0]  nh;
        logic        [30:0] mh;
        logic        [15:0] fh;
        logic        [4:0]  nz;
        logic        [30:0] mz;
        logic        [15:0] fz;
        logic signed [41:0] ri;
        logic signed [22:0] l2;
        logic signed [39:0] prod;
        logic        [20:0] aden;
        logic               dneg;
        logic               dnz;
        logic        [38:0] dv;
        logic        [49:0] rem2;
        logic        [33:0] q2;
        logic               pos;
        logic        [15:0] crv;
        logic        [56:0] rem3;
        logic               ovf2;
        logic        [22:0] q3;
        logic        [35:0] sx;
        logic        [36:0] sres;
        logic        [22:0] aq;
        logic        [45:0] aqp;
        logic        [19:0] corr;
        logic        [1:0]  st;
    } t_ctx;

    // input preparation: differences, mean temperature terms
    function automatic t_ctx f_prep(t_in_word iw);
        t_ctx               c;
        logic signed [16:0] hs;
        logic signed [16:0] dts;
        int                 tmi;
        int                 tki;
        c   = '0;
        hs  = $signed({1'b0, iw.reference_height}) - $signed({1'b0, iw.displacement_height});
        dts = $signed({iw.air_temp[15], iw.air_temp})
            - $signed({iw.surface_temp[15], iw.surface_temp});
        tmi = int'(iw.air_temp) + int'(iw.surface_temp) + KELVIN2_Q8;
        tki = 2 * int'(iw.air_temp) + KELVIN2_Q8;
        c.eq   = (iw.air_temp == iw.surface_temp);
        c.bad  = !c.eq && (hs <= 0);
        c.neg  = dts[16];
        c.h    = hs[15:0];
        c.mag  = 16'(dts[16] ? -dts : dts);
        c.tm2  = 18'(tmi);
        c.tak2 = 18'(tki);
        c.w    = iw.wind_speed;
        c.z0   = (iw.roughness_length == 24'd0) ? 24'd1 : iw.roughness_length;
        return c;
    endfunction

    // first products and log2 normalization
    function automatic t_ctx f_mul1(t_ctx ci);
        t_ctx c;
        int   i;
        c    = ci;
        c.a1 = 36'(G_Q16) * 36'(c.mag);
        c.b1 = 32'(c.w) * 32'(c.w);
        c.nh = '0;
        for (i = 0; i < 16; i++) begin
            if (c.h[i]) c.nh = 4'(i);
        end
        c.nz = '0;
        for (i = 0; i < 24; i++) begin
            if (c.z0[i]) c.nz = 5'(i);
        end
        c.mh = 31'(c.h) << (30 - int'(c.nh));
        c.mz = 31'(c.z0) << (30 - int'(c.nz));
        c.fh = '0;
        c.fz = '0;
        return c;
    endfunction

    // numerator and denominator of the richardson number
    function automatic t_ctx f_mul2(t_ctx ci);
        t_ctx c;
        c     = ci;
        c.num = (61'(c.a1) * 61'(c.h)) << 9;
        c.dd  = 50'(c.b1) * 50'(c.tm2);
        return c;
    endfunction

    // quotient overflow check, also covers zero wind
    function automatic t_ctx f_d1_init(t_ctx ci);
        t_ctx c;
        c      = ci;
        c.ovf1 = {30'b0, c.num} >= {c.dd, 41'b0};
        c.q1   = '0;
        return c;
    endfunction

    // one log2 squaring step
    function automatic void f_log_step(input logic [30:0] mi, input logic [15:0] fi,
                                       output logic [30:0] mo, output logic [15:0] fo);
        logic [61:0] sq;
        logic [31:0] m32;
        sq  = 62'(mi) * 62'(mi);
        m32 = sq[61:30];
        fo  = {fi[14:0], m32[31]};
        mo  = m32[31] ? m32[31:1] : m32[30:0];
    endfunction

    // one restoring division bit, plus log2 step on the early stages
    function automatic t_ctx f_d1_step(t_ctx ci, int bi, logic do_log);
        t_ctx        c;
        logic [90:0] t;
        logic [30:0] m;
        logic [15:0] f;
        c = ci;
        t = {41'b0, c.dd} << bi;
        if ({30'b0, c.num} >= t) begin
            c.num    = c.num - t[60:0];
            c.q1[bi] = 1'b1;
        end
        if (do_log) begin
            f_log_step(c.mh, c.fh, m, f);
            c.mh = m;
            c.fh = f;
            f_log_step(c.mz, c.fz, m, f);
            c.mz = m;
            c.fz = f;
        end
        return c;
    endfunction

    // signed richardson number and log ratio
    function automatic t_ctx f_ri(t_ctx ci);
        t_ctx               c;
        logic        [40:0] rmag;
        logic signed [41:0] rs;
        int                 la;
        int                 lb;
        c    = ci;
        rmag = (c.ovf1 || c.q1 > (41'd1 << 40)) ? (41'd1 << 40) : c.q1;
        rs   = $signed({1'b0, rmag});
        c.ri = c.neg ? -rs : rs;
        la   = int'({c.nh, c.fh});
        lb   = int'({c.nz, c.fz});
        c.l2 = 23'(la - lb + 524288);
        return c;
    endfunction

    // natural log scaling
    function automatic t_ctx f_lnp(t_ctx ci);
        t_ctx   c;
        longint p;
        c      = ci;
        p      = longint'(c.l2) * LN2_Q16;
        c.prod = 40'(p);
        return c;
    endfunction

    // log divisor, truncated toward zero
    function automatic t_ctx f_den(t_ctx ci);
        t_ctx   c;
        longint p;
        longint d;
        c = ci;
        p = longint'(c.prod);
        if (p < 0) d = -((-p) >>> 16);
        else       d = p >>> 16;
        d      = d + FIVE_Q16;
        c.dneg = (d < 0);
        c.dnz  = (d != 0);
        c.aden = 21'((d < 0) ? -d : d);
        return c;
    endfunction

    // limit division setup
    function automatic t_ctx f_d2_init(t_ctx ci);
        t_ctx c;
        c      = ci;
        c.dv   = 39'(c.tm2) * 39'(c.aden);
        c.rem2 = 50'(c.tak2) << 32;
        c.q2   = '0;
        return c;
    endfunction

    // one limit division bit
    function automatic t_ctx f_d2_step(t_ctx ci, int bi);
        t_ctx        c;
        logic [71:0] t;
        c = ci;
        t = {33'b0, c.dv} << bi;
        if ({22'b0, c.rem2} >= t) begin
            c.rem2   = c.rem2 - t[49:0];
            c.q2[bi] = 1'b1;
        end
        return c;
    endfunction

    // cap at the log-based limit
    function automatic t_ctx f_lim(t_ctx ci);
        t_ctx               c;
        logic signed [41:0] lim;
        c   = ci;
        lim = $signed({8'b0, c.q2});
        if (c.dneg) lim = -lim;
        if (c.dnz && c.ri > lim) c.ri = lim;
        return c;
    endfunction

    // setup of stable division and unstable square root
    function automatic t_ctx f_d3_init(t_ctx ci, logic [15:0] crit);
        t_ctx   c;
        longint rc;
        longint arg;
        c      = ci;
        c.pos  = (c.ri > 0);
        c.crv  = (crit == 16'd0) ? 16'd1 : crit;
        c.rem3 = {c.ri[40:0], 16'b0};
        c.ovf2 = c.rem3 >= {18'b0, c.crv, 23'b0};
        c.q3   = '0;
        rc     = (c.ri < -42'sd32768) ? -64'sd32768 : longint'(c.ri);
        arg    = 65536 - 16 * rc;
        c.sx   = {20'(arg), 16'b0};
        c.sres = '0;
        return c;
    endfunction

    // one division bit and, on the early stages, one square root digit
    function automatic t_ctx f_d3_step(t_ctx ci, int bi, int si, logic do_sq);
        t_ctx        c;
        logic [56:0] t;
        logic [36:0] b;
        logic [36:0] tmp;
        c = ci;
        t = 57'(c.crv) << bi;
        if (c.rem3 >= t) begin
            c.rem3   = c.rem3 - t;
            c.q3[bi] = 1'b1;
        end
        if (do_sq) begin
            b   = 37'd1 << (2 * si);
            tmp = c.sres + b;
            if (37'(c.sx) >= tmp) begin
                c.sx   = c.sx - tmp[35:0];
                c.sres = (c.sres >> 1) + b;
            end else begin
                c.sres = c.sres >> 1;
            end
        end
        return c;
    endfunction

    // square of the stable factor
    function automatic t_ctx f_sqr(t_ctx ci);
        t_ctx               c;
        logic signed [24:0] qq;
        c    = ci;
        qq   = 25'sd65536 - $signed({2'b0, c.q3});
        c.aq = 23'(qq[24] ? -qq : qq);
        c.aqp = 46'(c.aq) * 46'(c.aq);
        return c;
    endfunction

    // result select and saturation
    function automatic t_ctx f_fin(t_ctx ci);
        t_ctx        c;
        logic [45:0] v;
        c = ci;
        v = (c.aqp + 46'd32768) >> 16;
        if (c.eq) begin
            c.corr = ONE_Q16;
            c.st   = ST_OK;
        end else if (c.bad) begin
            c.corr = ONE_Q16;
            c.st   = ST_BAD;
        end else if (c.pos) begin
            if (c.ovf2 || c.aq[22] || v > 46'(CORR_MAX)) begin
                c.corr = CORR_MAX;
                c.st   = ST_SAT;
            end else begin
                c.corr = v[19:0];
                c.st   = ST_OK;
            end
        end else begin
            c.corr = c.sres[19:0];
            c.st   = ST_OK;
        end
        return c;
    endfunction

    logic [15:0] r_crit;
    logic [NSTG-1:0] r_vld;
    t_ctx r_pipe [NSTG];
    t_ctx n_pipe [NSTG];
    logic adv;

    // critical richardson register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crit <= CRIT_RESET;
        end else if (i_cfg_we) begin
            r_crit <= i_cfg_data;
        end
    end

    // whole pipe advances unless the output word is held
    assign adv        = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready = adv;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // stage logic and registers
    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        if (k == STG_PREP) begin : g_prep
            assign n_pipe[k] = f_prep(i_in_word);
        end else if (k == STG_MUL1) begin : g_mul1
            assign n_pipe[k] = f_mul1(r_pipe[k-1]);
        end else if (k == STG_MUL2) begin : g_mul2
            assign n_pipe[k] = f_mul2(r_pipe[k-1]);
        end else if (k == STG_D1I) begin : g_d1i
            assign n_pipe[k] = f_d1_init(r_pipe[k-1]);
        end else if (k < STG_RI) begin : g_d1s
            localparam int J = k - STG_D1S;
            assign n_pipe[k] = f_d1_step(r_pipe[k-1], D1_BITS - 1 - J, J < LOG_STEPS);
        end else if (k == STG_RI) begin : g_ri
            assign n_pipe[k] = f_ri(r_pipe[k-1]);
        end else if (k == STG_LNP) begin : g_lnp
            assign n_pipe[k] = f_lnp(r_pipe[k-1]);
        end else if (k == STG_DEN) begin : g_den
            assign n_pipe[k] = f_den(r_pipe[k-1]);
        end else if (k == STG_D2I) begin : g_d2i
            assign n_pipe[k] = f_d2_init(r_pipe[k-1]);
        end else if (k < STG_LIM) begin : g_d2s
            localparam int J = k - STG_D2S;
            assign n_pipe[k] = f_d2_step(r_pipe[k-1], D2_BITS - 1 - J);
        end else if (k == STG_LIM) begin : g_lim
            assign n_pipe[k] = f_lim(r_pipe[k-1]);
        end else if (k == STG_D3I) begin : g_d3i
            assign n_pipe[k] = f_d3_init(r_pipe[k-1], r_crit);
        end else if (k < STG_SQR) begin : g_d3s
            localparam int J = k - STG_D3S;
            assign n_pipe[k] = f_d3_step(r_pipe[k-1], D3_BITS - 1 - J,
                                         SQ_BITS - 1 - J, J < SQ_BITS);
        end else if (k == STG_SQR) begin : g_sqr
            assign n_pipe[k] = f_sqr(r_pipe[k-1]);
        end else begin : g_fin
            assign n_pipe[k] = f_fin(r_pipe[k-1]);
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    // output word
    assign o_out_valid           = r_vld[NSTG-1];
    assign o_out_word.correction = r_pipe[NSTG-1].corr;
    assign o_out_word.status     = r_pipe[NSTG-1].st;

    // an accepted word enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word missing from first stage");

    // a stalled pipe keeps its valid bits
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |=> $stable(r_vld))
        else $error("valid bits moved during stall");

    // invalid geometry returns one
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_BAD) |-> o_out_word.correction == ONE_Q16)
        else $error("invalid geometry without unit correction");

    // saturation flag only at the maximum
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status == ST_SAT) |-> o_out_word.correction == CORR_MAX)
        else $error("saturation flag with non-maximum correction");

endmodule

>>> tb/testbench.sv
// testbench for the richardson stability correction block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rsc_pkg::*;

    localparam int PIPE_LAT = 110;

    // scoreboard: predicts the correction word and checks the output stream
    class correction_board;
        t_out_word   pending[$];
        logic [15:0] crit;
        int          mismatches;

        function new();
            crit = CRIT_RESET;
            mismatches = 0;
        endfunction

        // log2 in q.16 with a truncating squaring chain
        function longint log2_fix(longint unsigned v);
            longint unsigned m;
            int n;
            int f;
            v = v & 24'hFFFFFF;
            if (v == 0) v = 1;
            n = 0;
            while (n < 30 && (v >> (n + 1)) != 0) n++;
            m = v << (30 - n);
            f = 0;
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                f = f << 1;
                if (m >= (64'd1 << 31)) begin
                    m = m >> 1;
                    f = f | 1;
                end
            end
            return (longint'(n) << 16) | longint'(f);
        endfunction

        function longint unsigned root_fix(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function t_out_word predict(t_in_word w);
            t_out_word o;
            longint zh, dh, ts, ta, h, dt, tm2, ri, lim, l2, den, q;
            longint unsigned mag, rmag, num, dd, c, r, aq, corr, tak2, aden, z0;
            longint unsigned wnd;
            corr = ONE_Q16;
            o.status = ST_OK;
            zh = w.reference_height;
            dh = w.displacement_height;
            ts = longint'(w.surface_temp);
            ta = longint'(w.air_temp);
            wnd = w.wind_speed;
            z0 = w.roughness_length;
            if (z0 == 0) z0 = 1;
            if (ta != ts) begin
                h = zh - dh;
                if (h <= 0) begin
                    o.status = ST_BAD;
                end else begin
                    dt = ta - ts;
                    mag = (dt < 0) ? -dt : dt;
                    tm2 = ta + ts + KELVIN2_Q8;
                    if (wnd == 0) begin
                        rmag = 64'd1 << 40;
                    end else begin
                        num = 64'd642908 * mag * longint'(h) * 512;
                        dd = longint'(tm2) * wnd * wnd;
                        rmag = num / dd;
                        if (rmag > (64'd1 << 40)) rmag = 64'd1 << 40;
                    end
                    ri = (dt < 0) ? -longint'(rmag) : longint'(rmag);
                    l2 = log2_fix(h) - log2_fix(z0) + (longint'(8) << 16);
                    den = (l2 * LN2_Q16) / 65536 + FIVE_Q16;
                    if (den != 0) begin
                        tak2 = 2 * ta + KELVIN2_Q8;
                        aden = (den < 0) ? -den : den;
                        lim = longint'((tak2 << 32) / (longint'(tm2) * aden));
                        if (den < 0) lim = -lim;
                        if (ri > lim) ri = lim;
                    end
                    if (ri > 0) begin
                        c = (crit != 0) ? crit : 1;
                        r = (longint'(ri) << 16) / c;
                        q = 65536 - longint'(r);
                        aq = (q < 0) ? -q : q;
                        if (aq >= (64'd1 << 22)) begin
                            corr = CORR_MAX;
                            o.status = ST_SAT;
                        end else begin
                            corr = (aq * aq + 32768) >> 16;
                            if (corr > CORR_MAX) begin
                                corr = CORR_MAX;
                                o.status = ST_SAT;
                            end
                        end
                    end else begin
                        if (ri < -32768) ri = -32768;
                        corr = root_fix(longint'(65536 - 16 * ri) << 16);
                    end
                end
            end
            o.correction = corr[19:0];
            return o;
        endfunction

        function void note_input(t_in_word w);
            pending.push_back(predict(w));
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word corr=%0d st=%0d", got.correction, got.status);
                return;
            end
            exp_w = pending.pop_front();
            if (exp_w.correction !== got.correction || exp_w.status !== got.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected corr=%0d st=%0d got corr=%0d st=%0d",
                             exp_w.correction, exp_w.status, got.correction, got.status);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out_word;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    correction_board board;
    bit          hold_off;
    bit          rx_started;

    richardson_stability_correction_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // gap length: mostly short, a few long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one word and wait until it is taken; valid stays up afterwards
    task automatic send_word(t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_input(w);
    endtask

    // idle for a random gap, then offer the word
    task automatic send_with_gap(t_in_word w);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        send_word(w);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_crit(logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.crit = v;
    endtask

    function automatic t_in_word rand_cell();
        t_in_word w;
        int p;
        w.reference_height    = 16'($urandom);
        w.displacement_height = 16'($urandom);
        w.surface_temp        = 16'($urandom);
        w.air_temp            = 16'($urandom);
        w.wind_speed          = 16'($urandom);
        w.roughness_length    = 24'($urandom_range(1, 24'hFFFFFF));
        p = $urandom_range(0, 99);
        // mostly physically plausible cells so every branch gets exercised
        if (p < 70) begin
            w.reference_height    = 16'($urandom_range(256, 65535));
            w.displacement_height = 16'($urandom_range(0, w.reference_height - 1));
            w.surface_temp        = 16'(int'($urandom_range(0, 16000)) - 6000);
            w.air_temp            = 16'(int'(w.surface_temp)
                                        + int'($urandom_range(0, 4000)) - 2000);
            w.wind_speed          = ($urandom_range(0, 9) == 0) ? 16'd0
                                    : 16'($urandom_range(1, 8000));
            w.roughness_length    = 24'($urandom_range(1, 200000));
        end else if (p < 78) begin
            w.air_temp = w.surface_temp;
        end
        return w;
    endfunction

    function automatic t_in_word make_cell(int z, int d, int ts, int ta, int wv, int z0);
        t_in_word w;
        w.reference_height    = 16'(z);
        w.displacement_height = 16'(d);
        w.surface_temp        = 16'(ts);
        w.air_temp            = 16'(ta);
        w.wind_speed          = 16'(wv);
        w.roughness_length    = 24'(z0);
        return w;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_out_word);
    end

    initial begin
        int g;
        i_out_ready = 1'b0;
        wait (rx_started);
        forever begin
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial begin
        logic [15:0] crit_set[5];
        board = new();
        hold_off = 1'b0;
        rx_started = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rx_started = 1'b1;

        // directed cells at reset critical value
        send_with_gap(make_cell(2560, 0, 2560, 2560, 512, 65536));       // equal temps
        send_with_gap(make_cell(0, 65535, 0, 100, 512, 65536));          // bad geometry
        send_with_gap(make_cell(512, 512, 0, 100, 512, 65536));          // height equal
        send_with_gap(make_cell(2560, 256, 2560, 1280, 512, 6554));      // unstable
        send_with_gap(make_cell(2560, 256, 1280, 2560, 512, 6554));      // stable
        send_with_gap(make_cell(2560, 256, 1280, 2560, 0, 6554));        // zero wind stable
        send_with_gap(make_cell(2560, 256, 2560, 1280, 0, 6554));        // zero wind unstable
        send_with_gap(make_cell(65535, 0, -32768, 32767, 1, 1));         // extremes
        send_with_gap(make_cell(65535, 0, 32767, -32768, 65535, 24'hFFFFFF));
        send_with_gap(make_cell(1, 0, 0, 1, 65535, 0));                  // zero roughness
        send_with_gap(make_cell(1, 0, 0, 256, 16, 24'hFFFFFF));          // negative log term
        send_with_gap(make_cell(256, 0, 0, 256, 16, 16777));             // positive log term
        send_with_gap(make_cell(40000, 100, -5000, 9000, 64, 300));
        drain();

        crit_set[0] = 16'd0;
        crit_set[1] = 16'd1;
        crit_set[2] = 16'hFFFF;
        crit_set[3] = CRIT_RESET;
        crit_set[4] = 16'd40000;
        for (int ph = 0; ph < 5; ph++) begin
            write_crit(crit_set[ph]);
            send_with_gap(make_cell(2560, 256, 1280, 2560, 0, 6554));
            for (int k = 0; k < 80; k++) begin
                if (ph == 1 && k == 10) hold_off = 1'b1;
                if (ph == 1 && k >= 10 && k < 60) send_word(rand_cell());
                else send_with_gap(rand_cell());
                // pause until everything has come back
                if (ph == 2 && k == 40) begin
                    i_in_valid <= 1'b0;
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        drain();
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/rsc_pkg.sv
hw/rtl/richardson_stability_correction_top.sv
tb/testbench.sv
